/* hdl/kpc_pkg.sv */
// Package: shared types, codes and helpers for the keyed Polybius codec.
`default_nettype none

package kpc_pkg;

    localparam int KPC_CHAR_W      = 8;
    localparam int KPC_KEY_W       = 3;
    localparam int KPC_NUM_KEYS    = 5;
    localparam int KPC_CFG_IDX_W   = 3;
    localparam int KPC_CFG_DATA_W  = 3;
    localparam int KPC_QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_INVALID  = 2'd1,
        ERR_UNPAIRED = 2'd2,
        ERR_KEY      = 2'd3
    } err_t;

    typedef enum logic [KPC_CFG_IDX_W-1:0] {
        CFG_MODE = 3'd0,
        CFG_KEY0 = 3'd1,
        CFG_KEY1 = 3'd2,
        CFG_KEY2 = 3'd3,
        CFG_KEY3 = 3'd4,
        CFG_KEY4 = 3'd5
    } cfg_idx_t;

    localparam logic MODE_ENCIPHER = 1'b0;

    localparam logic [KPC_CHAR_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [KPC_CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [KPC_CHAR_W-1:0] CHAR_ONE    = 8'h31;
    localparam logic [KPC_CHAR_W-1:0] CHAR_FIVE   = 8'h35;
    localparam logic [KPC_CHAR_W-1:0] CHAR_UP_A   = 8'h41;
    localparam logic [KPC_CHAR_W-1:0] CHAR_UP_Z   = 8'h5A;
    localparam logic [KPC_CHAR_W-1:0] CHAR_LO_A   = 8'h61;
    localparam logic [KPC_CHAR_W-1:0] CHAR_LO_Z   = 8'h7A;
    localparam logic [KPC_CHAR_W-1:0] CASE_OFFSET = 8'h20;
    localparam logic [4:0]            IDX_J       = 5'd9;

    typedef logic [KPC_NUM_KEYS*KPC_KEY_W-1:0] keys_t;

    // one queued job: one or two result words
    typedef struct packed {
        logic                  two_words;
        err_t                  err;
        logic [KPC_CHAR_W-1:0] ch0;
        logic [KPC_CHAR_W-1:0] ch1;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // square index 0..24 -> row 0..4
    function automatic logic [2:0] kpc_row_of(input logic [4:0] idx);
        logic [2:0] row;
        if (idx >= 5'd20)
            row = 3'd4;
        else if (idx >= 5'd15)
            row = 3'd3;
        else if (idx >= 5'd10)
            row = 3'd2;
        else if (idx >= 5'd5)
            row = 3'd1;
        else
            row = 3'd0;
        return row;
    endfunction

    function automatic logic [4:0] kpc_times5(input logic [2:0] v);
        return {v, 2'b00} + {2'b00, v};
    endfunction

    function automatic logic [KPC_KEY_W-1:0] kpc_key_at(input keys_t keys,
                                                       input logic [2:0] sel);
        logic [KPC_KEY_W-1:0] k;
        unique case (sel)
            3'd0:    k = keys[0*KPC_KEY_W +: KPC_KEY_W];
            3'd1:    k = keys[1*KPC_KEY_W +: KPC_KEY_W];
            3'd2:    k = keys[2*KPC_KEY_W +: KPC_KEY_W];
            3'd3:    k = keys[3*KPC_KEY_W +: KPC_KEY_W];
            3'd4:    k = keys[4*KPC_KEY_W +: KPC_KEY_W];
            default: k = keys[0*KPC_KEY_W +: KPC_KEY_W];
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

/* hdl/kpc_if.sv */
// Interfaces: input and output word channels of the codec.
`default_nettype none

interface kpc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_message;

    modport source (output valid, output char_in, output end_of_message, input ready);
    modport sink   (input valid, input char_in, input end_of_message, output ready);
endinterface

interface kpc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic [1:0] error;
    logic       last;

    modport source (output valid, output char_out, output error, output last, input ready);
    modport sink   (input valid, input char_out, input error, input last, output ready);
endinterface

`default_nettype wire

/* hdl/kpc_front.sv */
// Front end: config registers, pair state, classification into jobs.
`default_nettype none

module kpc_front
    import kpc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    kpc_in_if.sink                         rx,
    input  wire logic                      cfg_we,
    input  wire logic [KPC_CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [KPC_CFG_DATA_W-1:0] cfg_data,
    input  wire q_status_t                 q_stat,
    output logic                           push,
    output job_t                           job
);

    logic                 mode_reg;
    logic [KPC_KEY_W-1:0] key_reg [KPC_NUM_KEYS];
    logic                 pending_reg;
    logic                 pending_next;
    logic [2:0]           pending_row_reg;
    logic [2:0]           pending_row_next;

    keys_t                 keys;
    logic                  key_ok;
    logic [KPC_CHAR_W-1:0] upper;
    logic                  is_letter;
    logic [4:0]            lidx;
    logic [4:0]            sidx;
    logic [2:0]            row;
    logic [2:0]            col;
    logic                  is_digit;
    logic [2:0]            dig_idx;
    logic [4:0]            sq_pos;
    logic [4:0]            sq_adj;
    logic                  has_result;
    logic                  accept;

    assign accept   = rx.valid && rx.ready;
    assign rx.ready = !q_stat.full;
    assign push     = accept && has_result;

    always_comb
    begin
        key_ok = 1'b1;
        for (int i = 0; i < KPC_NUM_KEYS; i++)
        begin
            keys[i*KPC_KEY_W +: KPC_KEY_W] = key_reg[i];
            if (key_reg[i] < 3'd1 || key_reg[i] > 3'd5)
                key_ok = 1'b0;
            for (int j = i + 1; j < KPC_NUM_KEYS; j++)
                if (key_reg[i] == key_reg[j])
                    key_ok = 1'b0;
        end
    end

    // encipher path
    always_comb
    begin
        if (rx.char_in >= CHAR_LO_A && rx.char_in <= CHAR_LO_Z)
            upper = rx.char_in - CASE_OFFSET;
        else
            upper = rx.char_in;
        is_letter = upper >= CHAR_UP_A && upper <= CHAR_UP_Z;
        lidx      = 5'(upper - CHAR_UP_A);
        sidx      = (lidx >= IDX_J) ? lidx - 5'd1 : lidx;
        row       = kpc_row_of(sidx);
        col       = 3'(sidx - kpc_times5(row));
    end

    // decipher path
    always_comb
    begin
        is_digit = rx.char_in >= CHAR_ONE && rx.char_in <= CHAR_FIVE;
        dig_idx  = 3'd0;
        for (int i = KPC_NUM_KEYS - 1; i >= 0; i--)
            if (key_reg[i] == rx.char_in[KPC_KEY_W-1:0])
                dig_idx = 3'(i);
        sq_pos = kpc_times5(pending_row_reg) + {2'b00, dig_idx};
        sq_adj = (sq_pos >= IDX_J) ? sq_pos + 5'd1 : sq_pos;
    end

    always_comb
    begin
        job.two_words    = 1'b0;
        job.err          = ERR_NONE;
        job.ch0          = '0;
        job.ch1          = '0;
        has_result       = 1'b1;
        pending_next     = 1'b0;
        pending_row_next = pending_row_reg;
        if (!key_ok)
        begin
            job.err = ERR_KEY;
        end
        else if (mode_reg == MODE_ENCIPHER)
        begin
            if (is_letter)
            begin
                job.two_words = 1'b1;
                job.ch0 = CHAR_ZERO | {5'b0, kpc_key_at(keys, row)};
                job.ch1 = CHAR_ZERO | {5'b0, kpc_key_at(keys, col)};
            end
            else if (rx.char_in == CHAR_SPACE)
            begin
                job.two_words = 1'b1;
                job.ch0 = CHAR_SPACE;
                job.ch1 = CHAR_SPACE;
            end
            else
            begin
                job.err = ERR_INVALID;
            end
        end
        else
        begin
            if (is_digit)
            begin
                if (pending_reg)
                    job.ch0 = CHAR_UP_A + {3'b000, sq_adj};
                else if (rx.end_of_message)
                    job.err = ERR_UNPAIRED;
                else
                begin
                    has_result       = 1'b0;
                    pending_next     = 1'b1;
                    pending_row_next = dig_idx;
                end
            end
            else if (rx.char_in == CHAR_SPACE)
            begin
                if (pending_reg)
                    job.err = ERR_UNPAIRED;
                else
                    job.ch0 = CHAR_SPACE;
            end
            else
            begin
                job.err = ERR_INVALID;
            end
            if (rx.end_of_message)
                pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_ENCIPHER;
            pending_reg     <= 1'b0;
            pending_row_reg <= 3'd0;
            for (int i = 0; i < KPC_NUM_KEYS; i++)
                key_reg[i] <= KPC_KEY_W'(i + 1);
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE:
                        mode_reg <= cfg_data[0];
                    CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3, CFG_KEY4:
                        key_reg[3'(cfg_index - CFG_KEY0)] <= cfg_data;
                    default:
                        ;
                endcase
            end
            if (accept)
            begin
                pending_reg     <= pending_next;
                pending_row_reg <= pending_row_next;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/kpc_queue.sv */
// Job queue between front and back end.
`default_nettype none

module kpc_queue
    import kpc_pkg::*;
#(
    parameter int DEPTH = KPC_QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head,
    output q_status_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = count_reg == CNT_W'(DEPTH);
    assign stat.empty = count_reg == '0;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

/* hdl/kpc_back.sv */
// Back end: expands jobs into result words through an output register.
`default_nettype none

module kpc_back
    import kpc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire q_status_t q_stat,
    input  wire job_t      head,
    output logic           pop,
    kpc_out_if.source      tx
);

    logic                  valid_reg;
    logic                  second_reg;
    logic [KPC_CHAR_W-1:0] char_reg;
    err_t                  err_reg;
    logic                  last_reg;
    logic [KPC_CHAR_W-1:0] second_char_reg;
    logic                  slot_free;

    assign slot_free   = !valid_reg || tx.ready;
    assign pop         = slot_free && !second_reg && !q_stat.empty;
    assign tx.valid    = valid_reg;
    assign tx.char_out = char_reg;
    assign tx.error    = err_reg;
    assign tx.last     = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            if (second_reg)
            begin
                valid_reg  <= 1'b1;
                second_reg <= 1'b0;
            end
            else
            begin
                valid_reg  <= !q_stat.empty;
                second_reg <= !q_stat.empty && head.two_words;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            if (second_reg)
            begin
                char_reg <= second_char_reg;
                err_reg  <= ERR_NONE;
                last_reg <= 1'b1;
            end
            else if (pop)
            begin
                char_reg        <= head.ch0;
                err_reg         <= head.err;
                last_reg        <= !head.two_words;
                second_char_reg <= head.ch1;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/keyed_polybius_codec.sv */
// Top level: keyed 5x5 Polybius square encipher/decipher stream codec.
//
//  channel | dir | handshake      | word contents
//  rx      | in  | valid/ready    | char_in[7:0], end_of_message
//  tx      | out | valid/ready    | char_out[7:0], error[1:0], last
//  cfg     | in  | cfg_we         | cfg_index[2:0], cfg_data[2:0]
//
// An input word is accepted every cycle while the job queue has room.
// Each job leaves as one or two output words, one per cycle while tx is
// ready; an enciphered letter or space gives two words, any other job one.
// Input words pass through the job queue and the output register to tx.
// Reset sets mode 0 and key 1..5, drops any held digit and empties the
// queue. tx stalls back up through the queue to rx.ready.
`default_nettype none

module keyed_polybius_codec
    import kpc_pkg::*;
#(
    parameter int QUEUE_DEPTH = KPC_QUEUE_DEPTH
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    kpc_in_if.sink                         rx,
    kpc_out_if.source                      tx,
    input  wire logic                      cfg_we,
    input  wire logic [KPC_CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [KPC_CFG_DATA_W-1:0] cfg_data
);

    q_status_t q_stat;
    logic      push;
    logic      pop;
    job_t      push_job;
    job_t      head;

    kpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .push      (push),
        .job       (push_job)
    );

    kpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    kpc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .head   (head),
        .pop    (pop),
        .tx     (tx)
    );

endmodule

`default_nettype wire
